// File: design/lshrt_pkg.sv
// ----------------------------------------------------------------------------
// lshrt_pkg
// Shared types and constants of the LSH reservoir table engine: item kinds,
// controller states, field widths and the command and status groups.
// ----------------------------------------------------------------------------
package lshrt_pkg;

	localparam int NUM_TABLES_DEF  = 4;
	localparam int NUM_BUCKETS_DEF = 1024;
	localparam int SLOT_DEPTH_DEF  = 32;
	localparam int RAND_DEPTH_DEF  = 1024;

	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 72;
	localparam int MODE_W     = 3;

	localparam int SIZE_W  = 6;
	localparam int LIMIT_W = 11;
	localparam int IDX_W   = 5;
	localparam int WORD_W  = 32;

	localparam int SIZE_RESET  = 32;
	localparam int LIMIT_RESET = 1024;

	// The live reservoir size never exceeds the width of slot_index.
	localparam int SIZE_CAP = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT  = 3'd0,
		MODE_READ    = 3'd1,
		MODE_LOAD    = 3'd2,
		MODE_ADVANCE = 3'd3,
		MODE_CLEAR   = 3'd4
	} mode_t;

	// Register indexes on the configuration port (paddr[2]).
	localparam logic REG_SIZE  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_INS,
		ST_ROUT,
		ST_ZERO
	} state_t;

	typedef struct packed {
		logic clr;        // zero one row of the count and slot stores
		logic take;       // input item accepted
		logic upd;        // write the bumped count, read the random table
		logic ins_emit;   // store the id and deliver the insert result
		logic rd_emit;    // deliver one slot of a bucket read
		logic zero_emit;  // deliver the result of an out-of-range address
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic in_ins;
		logic in_rd;
		logic in_range;
		logic out_free;
		logic rd_last;
	} sts_t;

endpackage

// File: design/lshrt_ctrl.sv
// ----------------------------------------------------------------------------
// lshrt_ctrl
// Controller of the engine: sequences the clearing pass, the insert
// read-modify-write, the slot-by-slot bucket read and out-of-range results.
// ----------------------------------------------------------------------------
module lshrt_ctrl import lshrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if ((sts.in_ins || sts.in_rd) && !sts.in_range) begin
						state_nxt = ST_ZERO;
					end else if (sts.in_ins) begin
						state_nxt = ST_CALC;
					end else if (sts.in_rd) begin
						state_nxt = ST_ROUT;
					end
				end
			end
			ST_CALC: begin
				state_nxt = ST_INS;
			end
			ST_INS: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_ROUT: begin
				if (sts.out_free && sts.rd_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_ZERO: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_CALC: begin
				cmd.upd = 1'b1;
			end
			ST_INS: begin
				cmd.ins_emit = sts.out_free;
			end
			ST_ROUT: begin
				cmd.rd_emit = sts.out_free;
			end
			ST_ZERO: begin
				cmd.zero_emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: design/lshrt_dp.sv
// ----------------------------------------------------------------------------
// lshrt_dp
// Datapath of the engine: bucket count store, bucket slot store (one row of
// slots per bucket), random location table, id base and output register.
// ----------------------------------------------------------------------------
module lshrt_dp import lshrt_pkg::*; #(
	parameter int NUM_TABLES  = NUM_TABLES_DEF,
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int SLOT_DEPTH  = SLOT_DEPTH_DEF,
	parameter int RAND_DEPTH  = RAND_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]     s_tuser,
	input  logic [SIZE_W-1:0]     live_size,
	input  logic [LIMIT_W-1:0]    rand_limit,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);

	localparam int NBKT    = NUM_TABLES * NUM_BUCKETS;
	localparam int BKT_AW  = (NBKT > 1) ? $clog2(NBKT) : 1;
	localparam int SLOT_AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int RAND_AW = (RAND_DEPTH > 1) ? $clog2(RAND_DEPTH) : 1;
	localparam logic [BKT_AW-1:0] LAST_ROW = BKT_AW'(NBKT - 1);
	localparam logic [WORD_W-1:0] RAND_TOP = WORD_W'(RAND_DEPTH - 1);

	// Input fields.
	logic [1:0]        in_tsel;
	logic [9:0]        in_bkt;
	logic [WORD_W-1:0] in_item;
	logic [WORD_W-1:0] in_offset;
	logic [9:0]        in_raddr;
	logic [WORD_W-1:0] in_rvalue;
	logic [WORD_W-1:0] in_step;
	mode_t             in_mode;

	assign in_tsel   = s_tdata[1:0];
	assign in_bkt    = s_tdata[11:2];
	assign in_item   = s_tdata[43:12];
	assign in_offset = s_tdata[75:44];
	assign in_raddr  = s_tdata[85:76];
	assign in_rvalue = s_tdata[117:86];
	assign in_step   = s_tdata[149:118];
	assign in_mode   = mode_t'(s_tuser);

	logic [WORD_W-1:0] in_addr_full;
	logic [BKT_AW-1:0] in_addr;
	logic [WORD_W-1:0] in_raddr_ext;
	logic              in_range;

	assign in_range = (WORD_W'(in_tsel) < WORD_W'(NUM_TABLES))
		&& (WORD_W'(in_bkt) < WORD_W'(NUM_BUCKETS));
	assign in_addr_full = WORD_W'(in_tsel) * WORD_W'(NUM_BUCKETS) + WORD_W'(in_bkt);
	assign in_addr      = in_addr_full[BKT_AW-1:0];
	assign in_raddr_ext = WORD_W'(in_raddr);

	// Stores.
	logic [WORD_W-1:0]                  cnt_mem  [NBKT];
	logic [SLOT_DEPTH-1:0][WORD_W-1:0]  slot_mem [NBKT];
	logic [WORD_W-1:0]                  rand_mem [RAND_DEPTH];

	logic [WORD_W-1:0]                  cnt_rd_q;
	logic [SLOT_DEPTH-1:0][WORD_W-1:0]  row_q;
	logic [WORD_W-1:0]                  rand_rd_q;
	logic [BKT_AW-1:0]                  addr_q;
	logic [WORD_W-1:0]                  id_q;
	logic [WORD_W-1:0]                  id_base_q;
	logic [BKT_AW-1:0]                  clr_q;
	logic [IDX_W-1:0]                   idx_q;

	// Random table index: min(limit - 1, count), then held inside the table.
	logic [LIMIT_W-1:0] lim_m1;
	logic [WORD_W-1:0]  ri_full;
	logic [WORD_W-1:0]  ri_clamp;
	logic [RAND_AW-1:0] ri;

	assign lim_m1   = (rand_limit == '0) ? '0 : rand_limit - LIMIT_W'(1);
	assign ri_full  = (cnt_rd_q < WORD_W'(lim_m1)) ? cnt_rd_q : WORD_W'(lim_m1);
	assign ri_clamp = (ri_full > RAND_TOP) ? RAND_TOP : ri_full;
	assign ri       = ri_clamp[RAND_AW-1:0];

	// Insert decision.
	logic [WORD_W-1:0] size_ext;
	logic              ins_lt;
	logic              ins_ok;
	logic [IDX_W-1:0]  ins_loc;
	logic [WORD_W-1:0] ins_loc_ext;
	logic [SLOT_AW-1:0] ins_slot;

	assign size_ext    = WORD_W'(live_size);
	assign ins_lt      = cnt_rd_q < size_ext;
	assign ins_ok      = ins_lt || (rand_rd_q < size_ext);
	assign ins_loc     = ins_lt ? cnt_rd_q[IDX_W-1:0] : rand_rd_q[IDX_W-1:0];
	assign ins_loc_ext = WORD_W'(ins_loc);
	assign ins_slot    = ins_loc_ext[SLOT_AW-1:0];

	// Bucket read.
	logic [WORD_W-1:0]  idx_ext;
	logic [SLOT_AW-1:0] rd_slot;
	logic               size_zero;
	logic               rd_last;

	assign idx_ext   = WORD_W'(idx_q);
	assign rd_slot   = idx_ext[SLOT_AW-1:0];
	assign size_zero = (live_size == '0);
	assign rd_last   = size_zero || ((SIZE_W'(idx_q) + SIZE_W'(1)) == live_size);

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			cnt_mem[clr_q] <= '0;
		end else if (cmd.upd && (cnt_rd_q != '1)) begin
			cnt_mem[addr_q] <= cnt_rd_q + WORD_W'(1);
		end
		if (cmd.take) begin
			cnt_rd_q <= cnt_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			slot_mem[clr_q] <= '0;
		end else if (cmd.ins_emit && ins_ok) begin
			slot_mem[addr_q][ins_slot] <= id_q;
		end
		if (cmd.take) begin
			row_q <= slot_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (in_mode == MODE_LOAD)
				&& (in_raddr_ext < WORD_W'(RAND_DEPTH))) begin
			rand_mem[in_raddr_ext[RAND_AW-1:0]] <= in_rvalue;
		end
		if (cmd.upd) begin
			rand_rd_q <= rand_mem[ri];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			addr_q <= in_addr;
			id_q   <= in_item + in_offset + id_base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= '0;
			clr_q     <= '0;
			idx_q     <= '0;
		end else begin
			if (cmd.take && (in_mode == MODE_ADVANCE)) begin
				id_base_q <= id_base_q + in_step;
			end else if (cmd.take && (in_mode == MODE_CLEAR)) begin
				id_base_q <= '0;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + BKT_AW'(1);
			end
			if (cmd.take) begin
				idx_q <= '0;
			end else if (cmd.rd_emit) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Output register.
	logic              out_load;
	logic              out_free;
	logic [WORD_W-1:0] val_nxt;
	logic [IDX_W-1:0]  sidx_nxt;
	logic [WORD_W-1:0] fill_nxt;
	logic              stored_nxt;
	logic              last_nxt;
	logic [WORD_W-1:0] val_q;
	logic [IDX_W-1:0]  sidx_q;
	logic [WORD_W-1:0] fill_q;
	logic              stored_q;
	logic              last_q;
	logic              valid_q;

	assign out_free = !valid_q || m_tready;
	assign out_load = cmd.ins_emit || cmd.rd_emit || cmd.zero_emit;

	always_comb begin
		val_nxt    = '0;
		sidx_nxt   = '0;
		fill_nxt   = '0;
		stored_nxt = 1'b0;
		last_nxt   = 1'b1;
		priority if (cmd.ins_emit) begin
			val_nxt    = ins_ok ? id_q : '0;
			sidx_nxt   = ins_ok ? ins_loc : '0;
			fill_nxt   = cnt_rd_q;
			stored_nxt = ins_ok;
		end else if (cmd.rd_emit) begin
			val_nxt  = size_zero ? '0 : row_q[rd_slot];
			sidx_nxt = size_zero ? '0 : idx_q;
			fill_nxt = cnt_rd_q;
			last_nxt = rd_last;
		end else begin
			last_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			val_q    <= val_nxt;
			sidx_q   <= sidx_nxt;
			fill_q   <= fill_nxt;
			stored_q <= stored_nxt;
			last_q   <= last_nxt;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {3'b000, fill_q, sidx_q, val_q};
	assign m_tuser  = stored_q;
	assign m_tlast  = last_q;

	assign sts.clr_done = (clr_q == LAST_ROW);
	assign sts.in_ins   = (in_mode == MODE_INSERT);
	assign sts.in_rd    = (in_mode == MODE_READ);
	assign sts.in_range = in_range;
	assign sts.out_free = out_free;
	assign sts.rd_last  = rd_last;

endmodule

// File: design/lsh_reservoir_table_engine.sv
// ----------------------------------------------------------------------------
// lsh_reservoir_table_engine
// LSH bucket store filled by reservoir sampling, with bucket read-out,
// random location loading and an id base, behind a configuration port.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------------
//  s_*      | in        | tvalid / tready  | tdata item fields, tuser mode
//  m_*      | out       | tvalid / tready  | tdata result fields, tuser stored,
//           |           |                  | tlast last result of the item
//  apb      | in        | psel / penable   | reservoir_size at 0, rand_limit at 4
//
// An insert accepts the item with the count and slot row read, updates the
// count with the random table read, then does the slot write and result.
// A bucket read gives one result per slot in use, at least one; an insert or
// read of an out-of-range bucket gives one zero result; other items give none.
// After reset a clearing pass zeroes one bucket row of the count and slot
// stores per cycle, all NUM_TABLES * NUM_BUCKETS rows, with s_tready low.
// A stalled output holds the controller in its result state until taken.
module lsh_reservoir_table_engine import lshrt_pkg::*; #(
	parameter int NUM_TABLES  = NUM_TABLES_DEF,
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int SLOT_DEPTH  = SLOT_DEPTH_DEF,
	parameter int RAND_DEPTH  = RAND_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// table_sel[1:0], bucket[11:2], item_id[43:12], data_offset[75:44],
	// rand_addr[85:76], rand_value[117:86], base_step[149:118]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode[2:0]
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// slot_value[31:0], slot_index[36:32], fill_count[68:37]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// stored[0]
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int SIZE_LIM = (SLOT_DEPTH < SIZE_CAP) ? SLOT_DEPTH : SIZE_CAP;

	logic [SIZE_W-1:0]  size_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [SIZE_W-1:0]  live_size;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_W'(SIZE_RESET);
			limit_q <= LIMIT_W'(LIMIT_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SIZE:  size_q  <= pwdata[SIZE_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				default:   size_q  <= size_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SIZE:  prdata = 32'(size_q);
			REG_LIMIT: prdata = 32'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// Slots in use, held to the slot store depth and the slot_index range.
	assign live_size = (size_q > SIZE_W'(SIZE_LIM)) ? SIZE_W'(SIZE_LIM) : size_q;

	cmd_t cmd;
	sts_t sts;

	lshrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lshrt_dp #(
		.NUM_TABLES  (NUM_TABLES),
		.NUM_BUCKETS (NUM_BUCKETS),
		.SLOT_DEPTH  (SLOT_DEPTH),
		.RAND_DEPTH  (RAND_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.live_size  (live_size),
		.rand_limit (limit_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// An insert or read holds off the next item until its results are out.
	a_busy_after_bucket_op: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_INSERT || s_tuser == MODE_READ)
		|=> !s_tready)
		else $error("input accepted right after a bucket operation");

	a_stored_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (SIZE_W'(m_tdata[36:32]) < live_size))
		else $error("stored slot index beyond reservoir size");

	a_stored_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("stored result is not the last result of its item");

	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !s_tready && !m_tvalid)
		else $error("traffic during the clearing pass");

endmodule
